// File: rtl/core/assert_macros.svh
// Assertion macros shared by the collision test RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk while aresetn is high.
`define PCT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("pct assertion failed");

// Checks that a trigger is followed by a consequence in the next cycle.
`define PCT_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("pct sequencing assertion failed");

`endif

// File: rtl/core/pct_pkg.sv
// Package for the polygon collision test: widths, vertex type, cause codes,
// sequencer states and multiplier control. No dependencies.
package pct_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int MAX_V     = 64;
    localparam int ADDR_W    = $clog2(MAX_V);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int MINRUN_W  = 16;
    localparam int WALK_W    = COORD_W + 2;
    localparam int OP_W      = COORD_W + 3;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int NPROD     = 6;
    localparam int STEP_W    = 3;
    localparam int NACC      = 3;
    localparam int OUT_W     = 8;

    localparam logic [MINRUN_W-1:0] MIN_RUN_RESET =
        MINRUN_W'(((3 << FRAC_BITS) + 5) / 10);

    typedef logic [2:0] cause_t;
    localparam cause_t CAUSE_FEW  = 3'd0;
    localparam cause_t CAUSE_BOX  = 3'd1;
    localparam cause_t CAUSE_EDGE = 3'd2;
    localparam cause_t CAUSE_BIN  = 3'd3;
    localparam cause_t CAUSE_AIN  = 3'd4;

    localparam logic [STEP_W-1:0] LAST_SEG = STEP_W'(NPROD - 1);
    localparam logic [STEP_W-1:0] LAST_PIP = STEP_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] last;
    } xm_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK,
        ST_AI, ST_AIW, ST_AR, ST_ARW,
        ST_BI, ST_BIW, ST_BR, ST_BRW,
        ST_XM, ST_XW,
        ST_PI, ST_PIW, ST_PR, ST_PRW, ST_PM, ST_PW,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/pct_vram.sv
// Vertex store: one write port and one registered read port.
// Depends on pct_pkg for the vertex type and depth.
module pct_vram
    import pct_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  vertex_t           wdata,
    input  logic [ADDR_W-1:0] raddr,
    output vertex_t           rdata
);

    vertex_t mem [MAX_V];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/pct_xmul.sv
// Shared multiplier that forms up to three cross products a*b - c*d,
// one registered product per cycle. Depends on pct_pkg.
module pct_xmul
    import pct_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  xm_ctl_t                 ctl,
    input  logic signed [OP_W-1:0]  op_a [NPROD],
    input  logic signed [OP_W-1:0]  op_b [NPROD],
    output logic signed [ACC_W-1:0] acc  [NACC],
    output logic                    done
);

    logic                     busy_reg;
    logic                     pvalid_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        pidx_reg;
    logic [STEP_W-1:0]        last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg [NACC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end else begin
            done_reg   <= pvalid_reg && (pidx_reg == last_reg);
            pvalid_reg <= busy_reg;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == last_reg) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            last_reg <= ctl.last;
        end
        if (busy_reg) begin
            prod_reg <= op_a[step_reg] * op_b[step_reg];
            pidx_reg <= step_reg;
        end
        if (pvalid_reg) begin
            if (pidx_reg[0]) begin
                acc_reg[pidx_reg[2:1]] <= acc_reg[pidx_reg[2:1]] - ACC_W'(prod_reg);
            end else begin
                acc_reg[pidx_reg[2:1]] <= ACC_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/polygon_collision_test_core.sv
// Polygon collision test. Vertices stream in one per cycle while the core is
// idle. The last vertex of polygon B starts an evaluation in which the input
// is stalled: edge pairs of A and B are tested first, with the single shared
// multiplier forming six products per pair, then each vertex test walks the
// polygon edges and uses the multiplier only when an edge spans the test
// point's x. Depends on pct_pkg, pct_vram, pct_xmul
// and assert_macros.svh.
`include "assert_macros.svh"

module polygon_collision_test_core
    import pct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [MINRUN_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*COORD_W-1:0] s_tdata,  // vertex_x, vertex_y
    input  logic                s_tuser,   // poly_sel
    input  logic                s_tlast,   // last_vertex
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // collide, cause[2:0], overflow, zero fill
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_a_reg, cnt_b_reg, i_reg, j_reg;
    logic                      drop_reg, pip_b_reg, inside_reg, collide_reg;
    cause_t                    cause_reg;
    logic [MINRUN_W-1:0]       minrun_reg, mr_reg;
    logic signed [COORD_W-1:0] box_reg [8];
    logic signed [WALK_W-1:0]  px_reg, py_reg, x1_reg, y1_reg;
    logic signed [WALK_W-1:0]  qx_reg, qy_reg, x3_reg, y3_reg;
    logic signed [OP_W-1:0]    r1_reg, dy1_reg, r2_reg, dy2_reg;
    logic                      m_valid_reg;
    logic [OUT_W-1:0]          m_data_reg;

    logic                      accept, room_a, room_b, first;
    logic signed [COORD_W-1:0] in_x, in_y;
    vertex_t                   in_v, rd_a, rd_b, rd_poly, rd_pt;
    logic [ADDR_W-1:0]         addr_a, addr_b;
    logic [CNT_W-1:0]          a_start, b_start, a_i0, b_j0, n_poly;
    logic [CNT_W:0]            total;
    logic                      few, disj, edges_ok, seg_hit, tog, btw, inside_now;
    logic                      i_more, j_more, k_more, load_out;
    logic signed [WALK_W-1:0]  nax, nay, nbx, nby, npx, npy, mr_w;
    logic signed [OP_W-1:0]    ra, rb, ra_abs, rb_abs, mr_op, dxp;
    logic signed [OP_W-1:0]    op_a [NPROD];
    logic signed [OP_W-1:0]    op_b [NPROD];
    logic signed [ACC_W-1:0]   acc [NACC];
    logic                      xm_done;
    xm_ctl_t                   xm_ctl;

    assign accept = s_tvalid && s_tready;
    assign in_x   = s_tdata[COORD_W-1:0];
    assign in_y   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_v   = '{y: in_y, x: in_x};
    assign room_a = cnt_a_reg < CNT_W'(MAX_V);
    assign room_b = cnt_b_reg < CNT_W'(MAX_V);
    assign first  = s_tuser ? (cnt_b_reg == '0) : (cnt_a_reg == '0);

    pct_vram u_store_a (
        .aclk  (aclk),
        .we    (accept && !s_tuser && room_a),
        .waddr (cnt_a_reg[ADDR_W-1:0]),
        .wdata (in_v),
        .raddr (addr_a),
        .rdata (rd_a)
    );

    pct_vram u_store_b (
        .aclk  (aclk),
        .we    (accept && s_tuser && room_b),
        .waddr (cnt_b_reg[ADDR_W-1:0]),
        .wdata (in_v),
        .raddr (addr_b),
        .rdata (rd_b)
    );

    pct_xmul u_xmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (xm_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc     (acc),
        .done    (xm_done)
    );

    assign total    = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign few      = (total <= (CNT_W+1)'(3)) || (cnt_a_reg == '0) || (cnt_b_reg == '0);
    assign disj     = (box_reg[1] < box_reg[4]) || (box_reg[0] > box_reg[5]) ||
                      (box_reg[3] < box_reg[6]) || (box_reg[2] > box_reg[7]);
    assign edges_ok = (cnt_a_reg >= CNT_W'(2)) && (cnt_b_reg >= CNT_W'(2));
    assign a_start  = (cnt_a_reg == CNT_W'(2)) ? '0 : cnt_a_reg - 1'b1;
    assign b_start  = (cnt_b_reg == CNT_W'(2)) ? '0 : cnt_b_reg - 1'b1;
    assign a_i0     = (cnt_a_reg == CNT_W'(2)) ? CNT_W'(1) : '0;
    assign b_j0     = (cnt_b_reg == CNT_W'(2)) ? CNT_W'(1) : '0;
    assign n_poly   = pip_b_reg ? cnt_b_reg : cnt_a_reg;
    assign i_more   = (i_reg + 1'b1) < cnt_a_reg;
    assign j_more   = (j_reg + 1'b1) < cnt_b_reg;
    assign k_more   = (i_reg + 1'b1) < n_poly;

    // Edge endpoint walk with the minimum run applied.
    assign mr_op  = OP_W'($signed({1'b0, mr_reg}));
    assign mr_w   = WALK_W'(mr_op);
    assign nax    = WALK_W'(rd_a.x);
    assign nay    = WALK_W'(rd_a.y);
    assign nbx    = WALK_W'(rd_b.x);
    assign nby    = WALK_W'(rd_b.y);
    assign ra     = OP_W'(nax) - OP_W'(px_reg);
    assign rb     = OP_W'(nbx) - OP_W'(qx_reg);
    assign ra_abs = (ra < 0) ? -ra : ra;
    assign rb_abs = (rb < 0) ? -rb : rb;

    // Vertex test: polygon vertex and test point come from opposite stores.
    assign rd_poly = pip_b_reg ? rd_b : rd_a;
    assign rd_pt   = pip_b_reg ? rd_a : rd_b;
    assign npx     = WALK_W'(rd_poly.x);
    assign npy     = WALK_W'(rd_poly.y);
    assign btw     = ((px_reg < qx_reg) && (qx_reg < npx)) ||
                     ((npx < qx_reg) && (qx_reg < px_reg));
    assign dxp     = OP_W'(px_reg) - OP_W'(x1_reg);
    assign tog     = ((dxp > 0) && (acc[0] > 0)) || ((dxp < 0) && (acc[0] < 0));
    assign inside_now = inside_reg ^ ((state_reg == ST_PW) && tog);

    assign seg_hit = ((acc[0] > 0) && (acc[1] > 0) && (acc[1] < acc[0]) &&
                      (acc[2] > 0) && (acc[2] < acc[0])) ||
                     ((acc[0] < 0) && (acc[1] < 0) && (acc[1] > acc[0]) &&
                      (acc[2] < 0) && (acc[2] > acc[0]));

    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        if ((state_reg == ST_PM) || (state_reg == ST_PW)) begin
            op_a[0] = OP_W'(qy_reg) - OP_W'(y1_reg);
            op_b[0] = dxp;
            op_a[1] = OP_W'(py_reg) - OP_W'(y1_reg);
            op_b[1] = OP_W'(qx_reg) - OP_W'(x1_reg);
            op_a[2] = '0;
            op_b[2] = '0;
            op_a[3] = '0;
            op_b[3] = '0;
            op_a[4] = '0;
            op_b[4] = '0;
            op_a[5] = '0;
            op_b[5] = '0;
        end else begin
            op_a[0] = r1_reg;
            op_b[0] = dy2_reg;
            op_a[1] = dy1_reg;
            op_b[1] = r2_reg;
            op_a[2] = OP_W'(x3_reg) - OP_W'(x1_reg);
            op_b[2] = dy2_reg;
            op_a[3] = OP_W'(y3_reg) - OP_W'(y1_reg);
            op_b[3] = r2_reg;
            op_a[4] = OP_W'(x3_reg) - OP_W'(x1_reg);
            op_b[4] = dy1_reg;
            op_a[5] = OP_W'(y3_reg) - OP_W'(y1_reg);
            op_b[5] = r1_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser && s_tlast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (few || disj) begin
                    state_next = ST_DONE;
                end else if (edges_ok) begin
                    state_next = ST_AI;
                end else begin
                    state_next = ST_PI;
                end
            end
            ST_AI:  state_next = ST_AIW;
            ST_AIW: state_next = ST_AR;
            ST_AR:  state_next = ST_ARW;
            ST_ARW: state_next = ST_BI;
            ST_BI:  state_next = ST_BIW;
            ST_BIW: state_next = ST_BR;
            ST_BR:  state_next = ST_BRW;
            ST_BRW: state_next = ST_XM;
            ST_XM:  state_next = ST_XW;
            ST_XW: begin
                if (xm_done) begin
                    if (seg_hit) begin
                        state_next = ST_DONE;
                    end else if (j_more) begin
                        state_next = ST_BR;
                    end else if (i_more) begin
                        state_next = ST_AR;
                    end else begin
                        state_next = ST_PI;
                    end
                end
            end
            ST_PI: begin
                if (n_poly >= CNT_W'(3)) begin
                    state_next = ST_PIW;
                end else if (pip_b_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_PIW: state_next = ST_PR;
            ST_PR:  state_next = ST_PRW;
            ST_PRW, ST_PW: begin
                if ((state_reg == ST_PRW) && btw) begin
                    state_next = ST_PM;
                end else if ((state_reg == ST_PW) && !xm_done) begin
                    state_next = ST_PW;
                end else if (k_more) begin
                    state_next = ST_PR;
                end else if (inside_now || pip_b_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PI;
                end
            end
            ST_PM:  state_next = ST_PW;
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        addr_a   = '0;
        addr_b   = '0;
        xm_ctl   = '{start: 1'b0, last: LAST_SEG};
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_AI:   addr_a = a_start[ADDR_W-1:0];
            ST_AR:   addr_a = i_reg[ADDR_W-1:0];
            ST_BI:   addr_b = b_start[ADDR_W-1:0];
            ST_BR:   addr_b = j_reg[ADDR_W-1:0];
            ST_XM:   xm_ctl = '{start: 1'b1, last: LAST_SEG};
            ST_PI: begin
                if (pip_b_reg) begin
                    addr_b = ADDR_W'(n_poly - 1'b1);
                end else begin
                    addr_a = ADDR_W'(n_poly - 1'b1);
                end
            end
            ST_PR: begin
                if (pip_b_reg) begin
                    addr_b = i_reg[ADDR_W-1:0];
                end else begin
                    addr_a = i_reg[ADDR_W-1:0];
                end
            end
            ST_PM:   xm_ctl = '{start: 1'b1, last: LAST_PIP};
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            drop_reg    <= 1'b0;
            minrun_reg  <= MIN_RUN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                minrun_reg <= cfg_wdata;
            end
            if (accept) begin
                if (s_tuser) begin
                    if (room_b) begin
                        cnt_b_reg <= cnt_b_reg + 1'b1;
                    end else begin
                        drop_reg <= 1'b1;
                    end
                end else begin
                    if (room_a) begin
                        cnt_a_reg <= cnt_a_reg + 1'b1;
                    end else begin
                        drop_reg <= 1'b1;
                    end
                end
            end
            if (load_out) begin
                cnt_a_reg   <= '0;
                cnt_b_reg   <= '0;
                drop_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser ? room_b : room_a)) begin
            if (s_tuser) begin
                if (first || in_x < box_reg[4]) box_reg[4] <= in_x;
                if (first || in_x > box_reg[5]) box_reg[5] <= in_x;
                if (first || in_y < box_reg[6]) box_reg[6] <= in_y;
                if (first || in_y > box_reg[7]) box_reg[7] <= in_y;
            end else begin
                if (first || in_x < box_reg[0]) box_reg[0] <= in_x;
                if (first || in_x > box_reg[1]) box_reg[1] <= in_x;
                if (first || in_y < box_reg[2]) box_reg[2] <= in_y;
                if (first || in_y > box_reg[3]) box_reg[3] <= in_y;
            end
        end
        if (load_out) begin
            m_data_reg <= {3'b000, drop_reg, cause_reg, collide_reg};
        end
        case (state_reg)
            ST_CHECK: begin
                mr_reg      <= (minrun_reg == '0) ? MINRUN_W'(1) : minrun_reg;
                pip_b_reg   <= 1'b0;
                collide_reg <= 1'b0;
                cause_reg   <= few ? CAUSE_FEW : (disj ? CAUSE_BOX : CAUSE_EDGE);
            end
            ST_AIW: begin
                px_reg <= nax;
                py_reg <= nay;
                i_reg  <= a_i0;
            end
            ST_ARW: begin
                x1_reg  <= px_reg;
                y1_reg  <= py_reg;
                py_reg  <= nay;
                dy1_reg <= OP_W'(nay) - OP_W'(py_reg);
                if (ra_abs < mr_op) begin
                    r1_reg <= mr_op;
                    px_reg <= px_reg + mr_w;
                end else begin
                    r1_reg <= ra;
                    px_reg <= nax;
                end
            end
            ST_BIW: begin
                qx_reg <= nbx;
                qy_reg <= nby;
                j_reg  <= b_j0;
            end
            ST_BRW: begin
                x3_reg  <= qx_reg;
                y3_reg  <= qy_reg;
                qy_reg  <= nby;
                dy2_reg <= OP_W'(nby) - OP_W'(qy_reg);
                if (rb_abs < mr_op) begin
                    r2_reg <= mr_op;
                    qx_reg <= qx_reg + mr_w;
                end else begin
                    r2_reg <= rb;
                    qx_reg <= nbx;
                end
            end
            ST_XW: begin
                if (xm_done) begin
                    if (seg_hit) begin
                        collide_reg <= 1'b1;
                    end else if (j_more) begin
                        j_reg <= j_reg + 1'b1;
                    end else if (i_more) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
            end
            ST_PI: begin
                if (n_poly < CNT_W'(3)) begin
                    pip_b_reg <= 1'b1;
                end
            end
            ST_PIW: begin
                qx_reg     <= WALK_W'(rd_pt.x);
                qy_reg     <= WALK_W'(rd_pt.y);
                px_reg     <= npx;
                py_reg     <= npy;
                i_reg      <= '0;
                inside_reg <= 1'b0;
            end
            ST_PRW, ST_PW: begin
                if (state_reg == ST_PRW) begin
                    x1_reg <= px_reg;
                    y1_reg <= py_reg;
                    px_reg <= npx;
                    py_reg <= npy;
                end
                if (!((state_reg == ST_PRW) && btw) &&
                    !((state_reg == ST_PW) && !xm_done)) begin
                    inside_reg <= inside_now;
                    if (k_more) begin
                        i_reg <= i_reg + 1'b1;
                    end else if (inside_now) begin
                        collide_reg <= 1'b1;
                        cause_reg   <= pip_b_reg ? CAUSE_AIN : CAUSE_BIN;
                    end else begin
                        pip_b_reg <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PCT_ASSERT(a_cnt_a_bound, cnt_a_reg <= CNT_W'(MAX_V))
    `PCT_ASSERT(a_cnt_b_bound, cnt_b_reg <= CNT_W'(MAX_V))
    `PCT_ASSERT_NEXT(a_eval_start, accept && s_tuser && s_tlast, state_reg == ST_CHECK)
    `PCT_ASSERT(a_no_collide_early,
        !(m_valid_reg && m_data_reg[0] &&
          (m_data_reg[3:1] == CAUSE_FEW || m_data_reg[3:1] == CAUSE_BOX)))
    `PCT_ASSERT(a_b_index, (state_reg == ST_BRW) |-> (j_reg < cnt_b_reg))

endmodule
